[rtl/inr_pkg.sv]
// Package for the exact integer Nth root core: widths, defaults and sequencer states.
`timescale 1ns / 1ps

package inr_pkg;

  localparam int DEGREE_WIDTH = 6;
  localparam int VALUE_WIDTH_DEFAULT = 31;
  localparam int MAX_DEGREE_DEFAULT = 63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EVAL,
    ST_CHECK
  } state_t;

endpackage

[rtl/exact_integer_nth_root_core.sv]
// Exact integer Nth root by bisection over a single shared multiplier.
`timescale 1ns / 1ps
// Sequence: an unsupported degree (above MAX_DEGREE) ends straight from idle, not found.
//   Otherwise each bisection step passes ST_SETUP, then alternates ST_EVAL and ST_CHECK
//   once per multiplication (k <= N); the search ends in ST_EVAL (found) when all N match
//   the radicand, or in ST_SETUP (range empty); at most VALUE_WIDTH steps.
// Throughput: one item at a time; busy is high whenever the sequencer is not idle, and a
//   new start is taken in the cycle done is high. The receiver cannot stall. Reset (rst,
//   synchronous) returns the sequencer to idle and clears busy and done.

module exact_integer_nth_root_core
  import inr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
  parameter int MAX_DEGREE  = MAX_DEGREE_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [DEGREE_WIDTH-1:0] root_degree,
  input  logic [VALUE_WIDTH-1:0]  radicand,
  output logic                    done,
  output logic                    found,
  output logic [VALUE_WIDTH-1:0]  root
);

  state_t                     state, state_next;
  logic [DEGREE_WIDTH-1:0]    degree, degree_next;
  logic [DEGREE_WIDTH-1:0]    count, count_next;
  logic [VALUE_WIDTH-1:0]     target, target_next;
  logic [VALUE_WIDTH:0]       lo, lo_next;
  logic [VALUE_WIDTH-1:0]     hi, hi_next;
  logic [VALUE_WIDTH-1:0]     mid, mid_next;
  logic [VALUE_WIDTH-1:0]     acc, acc_next;
  logic [2*VALUE_WIDTH-1:0]   prod, prod_next;
  logic                       done_next, found_next;
  logic [VALUE_WIDTH-1:0]     root_next;
  logic [VALUE_WIDTH+1:0]     span_sum;

  assign busy     = (state != ST_IDLE);
  assign span_sum = {1'b0, lo} + {2'b00, hi};

  always_comb begin
    state_next  = state;
    degree_next = degree;
    count_next  = count;
    target_next = target;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    acc_next    = acc;
    prod_next   = prod;
    done_next   = 1'b0;
    found_next  = found;
    root_next   = root;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          degree_next = root_degree;
          target_next = radicand;
          lo_next     = {{VALUE_WIDTH{1'b0}}, 1'b1};
          hi_next     = radicand;
          if ({1'b0, root_degree} > (DEGREE_WIDTH+1)'(MAX_DEGREE)) begin
            done_next  = 1'b1;
            found_next = 1'b0;
            root_next  = '0;
          end else begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        if (lo > {1'b0, hi}) begin
          done_next  = 1'b1;
          found_next = 1'b0;
          root_next  = '0;
          state_next = ST_IDLE;
        end else begin
          mid_next   = span_sum[VALUE_WIDTH:1];
          acc_next   = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
          count_next = '0;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (count == degree) begin
          if (acc == target) begin
            done_next  = 1'b1;
            found_next = 1'b1;
            root_next  = mid;
            state_next = ST_IDLE;
          end else begin
            lo_next    = {1'b0, mid} + {{VALUE_WIDTH{1'b0}}, 1'b1};
            state_next = ST_SETUP;
          end
        end else begin
          prod_next  = acc * mid;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (prod > {{VALUE_WIDTH{1'b0}}, target}) begin
          hi_next    = mid - {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
          state_next = ST_SETUP;
        end else begin
          acc_next   = prod[VALUE_WIDTH-1:0];
          count_next = count + {{(DEGREE_WIDTH-1){1'b0}}, 1'b1};
          state_next = ST_EVAL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    degree <= degree_next;
    count  <= count_next;
    target <= target_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    acc    <= acc_next;
    prod   <= prod_next;
    found  <= found_next;
    root   <= root_next;
  end

endmodule
